/* hw/rtl/kmcd_pkg.sv */
// Shared types and constants for the key matrix column debouncer.
package kmcd_pkg;

  // Fixed widths of the item fields
  localparam int unsigned ColFieldW = 4;
  localparam int unsigned RowFieldW = 8;
  // Column compare width: holds any column code and the largest column count
  localparam int unsigned ColCmpW   = 6;

  // Packed stream widths, padded to whole bytes
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 16;

  // Parameter defaults
  localparam int unsigned NumColumnsDef   = 16;
  localparam int unsigned HistoryDepthDef = 4;
  localparam int unsigned RowBitsDef      = 8;

  // One input item after the input register
  typedef struct packed {
    logic [ColFieldW-1:0] column;
    logic [RowFieldW-1:0] row_raw;
    logic                 scan_last;
  } item_t;

  // One result item
  typedef struct packed {
    logic [ColFieldW-1:0] column_out;
    logic [RowFieldW-1:0] debounced_row;
    logic                 any_pressed;
    logic                 scan_done;
  } res_t;

endpackage

/* hw/rtl/key_matrix_column_debouncer_core.sv */
// Top level of the key matrix column debouncer.
// Each input item carries one raw row sample for one matrix column; the block
// returns one result per item holding the column, the AND of that column's last
// HISTORY_DEPTH samples (a key reads pressed after HISTORY_DEPTH closed samples
// in a row and released at once), and the OR of all raw rows in the current
// scan, final on the item marked tlast. Columns at or above NUM_COLUMNS return
// a zero row and leave the history alone. Row bits at and above ROW_BITS are
// ignored. One item is taken every clock cycle while the result buffer has
// room; each item passes the input register, then the history lookup into the
// result buffer. A two-entry result buffer keeps input flowing for one more
// result while the consumer stalls. History and pointers are cleared by reset.
module key_matrix_column_debouncer_core #(
  parameter int unsigned NUM_COLUMNS   = kmcd_pkg::NumColumnsDef,
  parameter int unsigned HISTORY_DEPTH = kmcd_pkg::HistoryDepthDef,
  parameter int unsigned ROW_BITS      = kmcd_pkg::RowBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [kmcd_pkg::InDataW-1:0]  in_tdata,   // column[3:0], row_raw[11:4], zero
  input  logic                          in_tlast,   // scan_last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [kmcd_pkg::OutDataW-1:0] out_tdata,  // column_out[3:0], debounced_row[11:4],
                                                    // any_pressed[12], zero
  output logic                          out_tlast   // scan_done
);
  import kmcd_pkg::*;

  logic                 s1_valid_r;
  item_t                s1_r;
  logic                 s1_adv;
  logic                 buf_rdy;
  logic [RowFieldW-1:0] row_m;
  logic [RowFieldW-1:0] deb_row;
  logic                 any_pressed;
  res_t                 res;
  res_t                 out_res;
  logic                 in_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign s1_adv    = s1_valid_r && buf_rdy;
  assign in_tready = !s1_valid_r || buf_rdy;

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.column    <= in_tdata[ColFieldW-1:0];
      s1_r.row_raw   <= in_tdata[ColFieldW +: RowFieldW];
      s1_r.scan_last <= in_tlast;
    end
  end

  // Drop row bits beyond the matrix height
  always_comb begin
    for (int i = 0; i < RowFieldW; i++) begin
      row_m[i] = s1_r.row_raw[i] & (i < ROW_BITS);
    end
  end

  kmcd_hist #(
    .NUM_COLUMNS  (NUM_COLUMNS),
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .ROW_BITS     (ROW_BITS)
  ) u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (s1_adv),
    .column (s1_r.column),
    .row    (row_m),
    .deb_row(deb_row)
  );

  kmcd_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (s1_adv),
    .row_nz     (|row_m),
    .scan_last  (s1_r.scan_last),
    .any_pressed(any_pressed)
  );

  // Assemble the result item
  always_comb begin
    res.column_out    = s1_r.column;
    res.debounced_row = deb_row;
    res.any_pressed   = any_pressed;
    res.scan_done     = s1_r.scan_last;
  end

  kmcd_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (s1_adv),
    .push_res (res),
    .rdy      (buf_rdy),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  // Pack the result stream
  assign out_tdata = {{(OutDataW - ColFieldW - RowFieldW - 1){1'b0}},
                      out_res.any_pressed, out_res.debounced_row, out_res.column_out};
  assign out_tlast = out_res.scan_done;

endmodule

/* hw/rtl/kmcd_hist.sv */
// Per-column sample history rings, write pointers and the AND of the window.
module kmcd_hist #(
  parameter int unsigned NUM_COLUMNS   = kmcd_pkg::NumColumnsDef,
  parameter int unsigned HISTORY_DEPTH = kmcd_pkg::HistoryDepthDef,
  parameter int unsigned ROW_BITS      = kmcd_pkg::RowBitsDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           upd,
  input  logic [kmcd_pkg::ColFieldW-1:0] column,
  input  logic [kmcd_pkg::RowFieldW-1:0] row,
  output logic [kmcd_pkg::RowFieldW-1:0] deb_row
);
  import kmcd_pkg::*;

  localparam int unsigned ColIdxW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int unsigned PtrW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned RowW    = (ROW_BITS < RowFieldW) ? ROW_BITS : RowFieldW;
  localparam int unsigned WinW    = HISTORY_DEPTH * RowW;

  // One word per column holds the whole sample window, slot i in bits [i*RowW +: RowW]
  logic [WinW-1:0]    hist_r [NUM_COLUMNS];
  logic [PtrW-1:0]    wptr_r [NUM_COLUMNS];

  logic [ColCmpW-1:0] col_ext;
  logic               col_ok;
  logic [ColIdxW-1:0] idx;
  logic [PtrW-1:0]    ptr_cur;
  logic [PtrW-1:0]    ptr_use;
  logic [PtrW-1:0]    ptr_nxt;
  logic [RowW-1:0]    row_new;
  logic [WinW-1:0]    win_cur;
  logic [WinW-1:0]    win_nxt;
  logic [RowW-1:0]    and_acc;

  // Select the column, pick the write slot and AND the window with the new sample
  always_comb begin
    col_ext = ColCmpW'(column);
    col_ok  = col_ext < ColCmpW'(NUM_COLUMNS);
    idx     = col_ext[ColIdxW-1:0];
    ptr_cur = wptr_r[idx];
    if ({1'b0, ptr_cur} < (PtrW+1)'(HISTORY_DEPTH)) begin
      ptr_use = ptr_cur;
    end else begin
      ptr_use = '0;
    end
    if (ptr_use == PtrW'(HISTORY_DEPTH - 1)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_use + PtrW'(1);
    end
    row_new = row[RowW-1:0];
    win_cur = hist_r[idx];
    win_nxt = win_cur;
    and_acc = '1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (ptr_use == PtrW'(i)) begin
        win_nxt[i*RowW +: RowW] = row_new;
      end
      and_acc = and_acc & win_nxt[i*RowW +: RowW];
    end
    deb_row = col_ok ? RowFieldW'(and_acc) : '0;
  end

  // Store the updated window and advance the column pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        wptr_r[c] <= '0;
        hist_r[c] <= '0;
      end
    end else if (upd && col_ok) begin
      hist_r[idx] <= win_nxt;
      wptr_r[idx] <= ptr_nxt;
    end
  end

endmodule

/* hw/rtl/kmcd_scan.sv */
// Scan-wide OR of raw rows, cleared after the item that closes a scan.
module kmcd_scan (
  input  logic clk,
  input  logic rst_n,
  input  logic upd,
  input  logic row_nz,
  input  logic scan_last,
  output logic any_pressed
);

  logic any_r;

  // Include the current item in the running OR
  assign any_pressed = any_r | row_nz;

  // Hold the OR until the scan closes, then drop it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
    end else if (upd) begin
      any_r <= scan_last ? 1'b0 : any_pressed;
    end
  end

endmodule

/* hw/rtl/kmcd_obuf.sv */
// Two-entry result buffer: output register plus skid stage.
module kmcd_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  kmcd_pkg::res_t   push_res,
  output logic             rdy,
  output logic             out_valid,
  input  logic             out_ready,
  output kmcd_pkg::res_t   out_res
);
  import kmcd_pkg::*;

  logic main_v_r;
  logic skid_v_r;
  res_t main_r;
  res_t skid_r;
  logic pop;

  assign rdy       = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;
  assign pop       = main_v_r && out_ready;

  // Control: refill the output register from the skid stage first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload: move items along with the control
  always_ff @(posedge clk) begin
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= push_res;
      end
    end else if (push) begin
      skid_r <= push_res;
    end
  end

endmodule
